// ===== rtl/bc1d_pkg.sv =====
// ----------------------------------------------------------------------------
// bc1d_pkg
// Types, constants and helpers shared by the BC1 block decoder.
// ----------------------------------------------------------------------------
package bc1d_pkg;

    localparam int TEXELS = 16;
    localparam int POS_W  = $clog2(TEXELS);
    localparam int CH_W   = 8;
    localparam int SUM_W  = CH_W + 2;
    localparam int PROD_W = 2 * SUM_W;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TEXELS - 1);

    // floor(x / 3) == (x * 683) >> 11 for every x below 2048
    localparam logic [SUM_W-1:0] RECIP3     = SUM_W'(683);
    localparam int               RECIP3_SHR = 11;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

    localparam logic [1:0] SEL_A     = 2'd0;
    localparam logic [1:0] SEL_B     = 2'd1;
    localparam logic [1:0] SEL_MIX_1 = 2'd2;
    localparam logic [1:0] SEL_MIX_2 = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } t_sum;

    function automatic t_rgb expand565(input logic [15:0] c);
        t_rgb o;
        o.r = {c[15:11], c[15:13]};
        o.g = {c[10:5], c[10:9]};
        o.b = {c[4:0], c[4:2]};
        return o;
    endfunction

    function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(RECIP3);
        return prod[RECIP3_SHR +: CH_W];
    endfunction

    // two-to-one weighted sum, or plain sum in three-color mode
    function automatic logic [SUM_W-1:0] wsum(input logic [CH_W-1:0] x,
                                              input logic [CH_W-1:0] y,
                                              input logic            dbl);
        logic [SUM_W-1:0] xs;
        xs = dbl ? SUM_W'({x, 1'b0}) : SUM_W'(x);
        return xs + SUM_W'(y);
    endfunction

endpackage

// ===== rtl/bc1_block_decoder_top.sv =====
// ----------------------------------------------------------------------------
// bc1_block_decoder_top
// Decodes one BC1 4x4 block per input beat into sixteen RGBA texel beats.
// ----------------------------------------------------------------------------
// A block beat is taken into a three-stage pipeline (endpoint expansion,
// blend sums, divide-by-three palette), then into a serializer that emits one
// texel per cycle through an output register unless the output stalls; it
// takes the next block as the last texel is emitted, so it sets the
// sustained block rate. Up to three further blocks wait in the pipeline while
// a block is being emitted. An output stall holds the serializer, and each
// earlier stage holds only once the stage after it is full.
// ----------------------------------------------------------------------------
module bc1_block_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_color_a_565,
    input  logic [15:0] i_color_b_565,
    input  logic [31:0] i_index_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_texel_pos,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_last
);

    // stage 1: expanded endpoints
    logic              r1_v;
    bc1d_pkg::t_rgb    r1_a, r1_b;
    logic              r1_mode;
    logic [31:0]       r1_idx;

    // stage 2: blend sums
    logic              r2_v;
    bc1d_pkg::t_rgb    r2_a, r2_b;
    bc1d_pkg::t_sum    r2_p, r2_q;
    logic              r2_mode;
    logic [31:0]       r2_idx;

    // stage 3: full palette
    logic              r3_v;
    bc1d_pkg::t_rgb    r3_a, r3_b, r3_c2, r3_c3;
    logic              r3_mode;
    logic [31:0]       r3_idx;

    // serializer
    logic                           r_sr_v;
    bc1d_pkg::t_rgb                 r_sr_a, r_sr_b, r_sr_c2, r_sr_c3;
    logic                           r_sr_mode;
    logic [31:0]                    r_sr_idx;
    logic [bc1d_pkg::POS_W-1:0]     r_cnt;

    // output register
    logic                           r_o_valid;
    logic [bc1d_pkg::POS_W-1:0]     r_o_pos;
    bc1d_pkg::t_rgb                 r_o_rgb;
    logic [7:0]                     r_o_alpha;
    logic                           r_o_last;

    logic out_free, emit, sr_take, en3, en2, en1;
    bc1d_pkg::t_rgb n_a, n_b, n_c2, n_c3, n_sel_rgb;
    bc1d_pkg::t_sum n_p, n_q;
    logic [7:0]     n_sel_alpha;

    assign out_free = !r_o_valid || i_ready;
    assign emit     = r_sr_v && out_free;
    assign sr_take  = !r_sr_v || (emit && (r_cnt == bc1d_pkg::LAST_POS));
    assign en3      = !r3_v || sr_take;
    assign en2      = !r2_v || en3;
    assign en1      = !r1_v || en2;
    assign o_ready  = en1;

    always_comb begin
        n_a = bc1d_pkg::expand565(i_color_a_565);
        n_b = bc1d_pkg::expand565(i_color_b_565);

        n_p.r = bc1d_pkg::wsum(r1_a.r, r1_b.r, r1_mode);
        n_p.g = bc1d_pkg::wsum(r1_a.g, r1_b.g, r1_mode);
        n_p.b = bc1d_pkg::wsum(r1_a.b, r1_b.b, r1_mode);
        n_q.r = bc1d_pkg::wsum(r1_b.r, r1_a.r, 1'b1);
        n_q.g = bc1d_pkg::wsum(r1_b.g, r1_a.g, 1'b1);
        n_q.b = bc1d_pkg::wsum(r1_b.b, r1_a.b, 1'b1);

        if (r2_mode) begin
            n_c2.r = bc1d_pkg::div3(r2_p.r);
            n_c2.g = bc1d_pkg::div3(r2_p.g);
            n_c2.b = bc1d_pkg::div3(r2_p.b);
            n_c3.r = bc1d_pkg::div3(r2_q.r);
            n_c3.g = bc1d_pkg::div3(r2_q.g);
            n_c3.b = bc1d_pkg::div3(r2_q.b);
        end else begin
            n_c2.r = r2_p.r[8:1];
            n_c2.g = r2_p.g[8:1];
            n_c2.b = r2_p.b[8:1];
            n_c3   = '0;
        end

        n_sel_alpha = bc1d_pkg::ALPHA_OPAQUE;
        unique case (r_sr_idx[1:0])
            bc1d_pkg::SEL_A:     n_sel_rgb = r_sr_a;
            bc1d_pkg::SEL_B:     n_sel_rgb = r_sr_b;
            bc1d_pkg::SEL_MIX_1: n_sel_rgb = r_sr_c2;
            bc1d_pkg::SEL_MIX_2: begin
                n_sel_rgb = r_sr_c3;
                if (!r_sr_mode) begin
                    n_sel_alpha = bc1d_pkg::ALPHA_CLEAR;
                end
            end
            default:             n_sel_rgb = r_sr_a;
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r_sr_v    <= 1'b0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (en1) begin
                r1_v <= i_valid;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
            if (sr_take) begin
                r_sr_v <= r3_v;
                r_cnt  <= '0;
            end else if (emit) begin
                r_cnt <= r_cnt + bc1d_pkg::POS_W'(1);
            end
            if (out_free) begin
                r_o_valid <= emit;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_a    <= n_a;
            r1_b    <= n_b;
            r1_mode <= (i_color_a_565 > i_color_b_565);
            r1_idx  <= i_index_word;
        end
        if (en2) begin
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_p    <= n_p;
            r2_q    <= n_q;
            r2_mode <= r1_mode;
            r2_idx  <= r1_idx;
        end
        if (en3) begin
            r3_a    <= r2_a;
            r3_b    <= r2_b;
            r3_c2   <= n_c2;
            r3_c3   <= n_c3;
            r3_mode <= r2_mode;
            r3_idx  <= r2_idx;
        end
        if (sr_take) begin
            r_sr_a    <= r3_a;
            r_sr_b    <= r3_b;
            r_sr_c2   <= r3_c2;
            r_sr_c3   <= r3_c3;
            r_sr_mode <= r3_mode;
            r_sr_idx  <= r3_idx;
        end else if (emit) begin
            r_sr_idx <= {2'b00, r_sr_idx[31:2]};
        end
        if (emit) begin
            r_o_pos   <= r_cnt;
            r_o_rgb   <= n_sel_rgb;
            r_o_alpha <= n_sel_alpha;
            r_o_last  <= (r_cnt == bc1d_pkg::LAST_POS);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_texel_pos = r_o_pos;
    assign o_red       = r_o_rgb.r;
    assign o_green     = r_o_rgb.g;
    assign o_blue      = r_o_rgb.b;
    assign o_alpha     = r_o_alpha;
    assign o_last      = r_o_last;

    a_last_texel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && (r_cnt == bc1d_pkg::LAST_POS) |=> r_o_valid && o_last)
        else $error("last texel of block not marked");

    a_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && (r_cnt != bc1d_pkg::LAST_POS) |=> r_sr_v && !o_last)
        else $error("serializer dropped a block before its last texel");

    a_clear_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_o_alpha != bc1d_pkg::ALPHA_OPAQUE) |->
            (r_o_rgb == '0) && (r_o_alpha == bc1d_pkg::ALPHA_CLEAR))
        else $error("transparent texel is not transparent black");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r1_v)
        else $error("accepted block not captured");

endmodule

// ===== dv/tb_bc1_block_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_bc1_block_decoder_top
// Self-checking bench for the BC1 block decoder.
// ----------------------------------------------------------------------------
// Compressed blocks are fed from a queue of pending blocks through a clocked
// driver. Each accepted block is decoded by an in-bench palette model into
// sixteen expected texels. A clocked monitor compares every texel beat, field
// by field, with the oldest expected texel. Directed blocks cover the endpoint
// extremes, both palette modes, equal endpoints and every index value. Random
// blocks follow, with sender and receiver idle rates set in three phases, the last with no idling.
// ----------------------------------------------------------------------------
module tb_bc1_block_decoder_top;

    typedef struct {
        logic [15:0] color_a;
        logic [15:0] color_b;
        logic [31:0] indices;
        int          send_idle;
        int          recv_idle;
        bit          drain;
    } t_block;

    typedef struct {
        logic [3:0] pos;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_texel;

    typedef struct {
        int red;
        int green;
        int blue;
        int alpha;
    } t_color;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_color_a_565 = '0;
    logic [15:0] i_color_b_565 = '0;
    logic [31:0] i_index_word = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_texel_pos;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic        o_last;

    t_block pending_blocks[$];
    t_texel expected_texels[$];
    int     recv_idle_pct = 0;
    int     error_count = 0;
    int     blocks_sent = 0;
    int     four_color_blocks = 0;
    int     three_color_blocks = 0;
    int     texels_checked = 0;

    bc1_block_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_color_a_565 (i_color_a_565),
        .i_color_b_565 (i_color_b_565),
        .i_index_word  (i_index_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_texel_pos   (o_texel_pos),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_color unpack565(input logic [15:0] c);
        t_color o;
        o.red   = int'({c[15:11], c[15:13]});
        o.green = int'({c[10:5], c[10:9]});
        o.blue  = int'({c[4:0], c[4:2]});
        o.alpha = int'(bc1d_pkg::ALPHA_OPAQUE);
        return o;
    endfunction

    function automatic t_color mix(input t_color x, input t_color y,
                                   input int wx, input int wy);
        t_color o;
        o.red   = (x.red * wx + y.red * wy) / (wx + wy);
        o.green = (x.green * wx + y.green * wy) / (wx + wy);
        o.blue  = (x.blue * wx + y.blue * wy) / (wx + wy);
        o.alpha = int'(bc1d_pkg::ALPHA_OPAQUE);
        return o;
    endfunction

    // build the palette and queue the sixteen texels of one block
    task automatic predict_texels(input logic [15:0] ca, input logic [15:0] cb,
                                  input logic [31:0] iw);
        t_color     pal[4];
        t_color     c;
        t_texel     t;
        logic [1:0] sel;
        pal[bc1d_pkg::SEL_A] = unpack565(ca);
        pal[bc1d_pkg::SEL_B] = unpack565(cb);
        if (ca > cb) begin
            pal[bc1d_pkg::SEL_MIX_1] = mix(pal[bc1d_pkg::SEL_A], pal[bc1d_pkg::SEL_B], 2, 1);
            pal[bc1d_pkg::SEL_MIX_2] = mix(pal[bc1d_pkg::SEL_A], pal[bc1d_pkg::SEL_B], 1, 2);
            four_color_blocks++;
        end else begin
            pal[bc1d_pkg::SEL_MIX_1] = mix(pal[bc1d_pkg::SEL_A], pal[bc1d_pkg::SEL_B], 1, 1);
            pal[bc1d_pkg::SEL_MIX_2] = '{0, 0, 0, int'(bc1d_pkg::ALPHA_CLEAR)};
            three_color_blocks++;
        end
        for (int i = 0; i < bc1d_pkg::TEXELS; i++) begin
            sel     = iw[2*i +: 2];
            c       = pal[sel];
            t.pos   = 4'(i);
            t.red   = 8'(c.red);
            t.green = 8'(c.green);
            t.blue  = 8'(c.blue);
            t.alpha = 8'(c.alpha);
            t.last  = (i == bc1d_pkg::TEXELS - 1);
            expected_texels.insert(expected_texels.size(), t);
        end
    endtask

    task automatic report_error(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int pos, input int got,
                               input int want);
        if (got != want)
            report_error($sformatf("texel %0d %s: got %0d, expected %0d",
                                   pos, name, got, want));
    endtask

    // driver
    always @(posedge i_clk) begin
        t_block blk;
        logic   next_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            next_valid = i_valid;
            if (i_valid && o_ready) begin
                predict_texels(i_color_a_565, i_color_b_565, i_index_word);
                blocks_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_blocks.size() != 0) begin
                blk = pending_blocks[0];
                if (!(blk.drain && expected_texels.size() != 0) &&
                    $urandom_range(99, 0) >= blk.send_idle) begin
                    blk = pending_blocks.pop_front();
                    i_color_a_565 <= blk.color_a;
                    i_color_b_565 <= blk.color_b;
                    i_index_word  <= blk.indices;
                    recv_idle_pct <= blk.recv_idle;
                    next_valid = 1'b1;
                end
            end
            i_valid <= next_valid;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_texel want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_texels.size() == 0) begin
                    report_error($sformatf("unexpected texel beat, pos %0d", o_texel_pos));
                end else begin
                    want = expected_texels.pop_front();
                    check_field("texel_pos", int'(want.pos), int'(o_texel_pos),
                                int'(want.pos));
                    check_field("red", int'(want.pos), int'(o_red), int'(want.red));
                    check_field("green", int'(want.pos), int'(o_green), int'(want.green));
                    check_field("blue", int'(want.pos), int'(o_blue), int'(want.blue));
                    check_field("alpha", int'(want.pos), int'(o_alpha), int'(want.alpha));
                    check_field("last", int'(want.pos), int'(o_last), int'(want.last));
                    texels_checked++;
                end
            end
            i_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [15:0] extremes[5] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
        logic [31:0] directed[14][3] = '{
            '{32'h0000, 32'h0000, 32'hE4E4E4E4},
            '{32'hFFFF, 32'h0000, 32'hE4E4E4E4},
            '{32'h0000, 32'hFFFF, 32'hE4E4E4E4},
            '{32'hFFFF, 32'hFFFF, 32'hFFFFFFFF},
            '{32'h1234, 32'h1234, 32'hFFFFFFFF},
            '{32'hF800, 32'h07E0, 32'h1B1B1B1B},
            '{32'h001F, 32'hF800, 32'h1B1B1B1B},
            '{32'h8001, 32'h8000, 32'hAAAAAAAA},
            '{32'h8000, 32'h8001, 32'hAAAAAAAA},
            '{32'hFFFF, 32'hFFFE, 32'h55555555},
            '{32'h0001, 32'h0000, 32'hFFFFFFFF},
            '{32'hA5A5, 32'h5A5A, 32'h00000000},
            '{32'h5A5A, 32'hA5A5, 32'hFFFFFFFF},
            '{32'h07FF, 32'hF81F, 32'h9C6C3936}
        };
        int     send_pct[3] = '{22, 45, 0};
        int     recv_pct[3] = '{45, 22, 0};
        int     phase;
        int     pick;
        t_block blk;

        foreach (directed[n]) begin
            blk = '{directed[n][0][15:0], directed[n][1][15:0], directed[n][2],
                    send_pct[0], recv_pct[0], 1'b0};
            pending_blocks.insert(pending_blocks.size(), blk);
        end
        for (int n = 0; n < 216; n++) begin
            phase = (n < 80) ? 0 : (n < 160) ? 1 : 2;
            blk.color_a = 16'($urandom);
            blk.color_b = 16'($urandom);
            blk.indices = $urandom;
            pick = $urandom_range(9, 0);
            if (pick == 0) begin
                blk.color_b = blk.color_a;
            end else if (pick == 1) begin
                blk.color_a = extremes[$urandom_range(4, 0)];
                blk.color_b = extremes[$urandom_range(4, 0)];
            end
            if ($urandom_range(7, 0) == 0)
                blk.indices = {16{2'($urandom_range(3, 0))}};
            blk.send_idle = send_pct[phase];
            blk.recv_idle = recv_pct[phase];
            blk.drain = (n == 80 || n == 160 || $urandom_range(39, 0) == 0);
            pending_blocks.insert(pending_blocks.size(), blk);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_blocks.size() != 0 || i_valid || expected_texels.size() != 0);
        repeat (32) @(posedge i_clk);

        $display("Sent %0d blocks (%0d four-color, %0d three-color), checked %0d texels",
                 blocks_sent, four_color_blocks, three_color_blocks, texels_checked);
        $display("Mismatches reported: %0d", error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bc1d_pkg.sv
rtl/bc1_block_decoder_top.sv
dv/tb_bc1_block_decoder_top.sv
